FILE: src/hilbert_fir_transformer_core_macros.svh
// Assertion macros used by the checker file of the Hilbert transformer.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef HILBERT_FIR_TRANSFORMER_CORE_MACROS_SVH
`define HILBERT_FIR_TRANSFORMER_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define HFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hilbert_fir_transformer_core: check failed");

// Next-cycle implication, switched off while reset is held.
`define HFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hilbert_fir_transformer_core: check failed");

`endif

FILE: src/hft_pkg.sv
// Types and constants of the Hilbert transformer core.
// Depends on nothing; used by the interfaces, the core and its checker.
package hft_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int QUAD_W    = 24;
    localparam int NUM_COEFS = 8;
    localparam int CFG_IDX_W = $clog2(NUM_COEFS);
    localparam int TAP_W     = CFG_IDX_W;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PROD_W    = DIFF_W + COEF_W;
    localparam int ACC_W     = PROD_W + 3;

    typedef logic signed [SAMPLE_W-1:0]  t_sample;
    typedef logic signed [COEF_W-1:0]    t_coef;
    typedef logic signed [QUAD_W-1:0]    t_quad;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic        [TAP_W-1:0]     t_tap;
    typedef logic signed [DIFF_W-1:0]    t_diff;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [ACC_W-1:0]     t_acc;

endpackage

FILE: src/hft_stream_if.sv
// Valid/ready channel interfaces for the Hilbert transformer core.
// Depends on hft_pkg for the payload types.
interface hft_in_if;
    import hft_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface hft_out_if;
    import hft_pkg::*;

    logic    valid;
    logic    ready;
    t_quad   quad_out;
    t_sample inphase_out;

    modport source (output valid, output quad_out, output inphase_out, input ready);
    modport sink   (input valid, input quad_out, input inphase_out, output ready);
endinterface

FILE: src/hilbert_fir_transformer_core.sv
// Top level of the 31-tap Hilbert transformer: ring buffer, shared MAC and sequencer.
// Depends on hft_pkg and the channel interfaces in hft_stream_if.sv.
//
//  channel   direction  request payload
//  i_in      in         sample_in (16 b signed)
//  o_out     out        quad_out (24 b signed), inphase_out (16 b signed)
//  i_cfg_*   in         coefficient write: index 0..7, 16 b data
//
// After acceptance, the sequencer issues ring reads for the tap pairs, then the centre tap,
// and the subtract, multiply, accumulate pipeline drains; the result is then registered
// and offered as the core returns to idle, and the next request can be taken from then on.
// Reset is synchronous; it clears the coefficients, the ring (through per-entry
// valid bits) and the write pointer. A result held in the output register stalls
// only the final step; the next request may be taken while that result waits.
module hilbert_fir_transformer_core #(
    parameter int RING_DEPTH    = 32,
    parameter int HALF_TAPS     = 8,
    parameter int CENTER_OFFSET = 15,
    parameter int FRAC_BITS     = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hft_in_if.sink           i_in,
    hft_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  hft_pkg::t_cfg_idx i_cfg_idx,
    input  hft_pkg::t_coef   i_cfg_data
);
    import hft_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(HALF_TAPS + 2);

    localparam logic [AW-1:0] LO_START  = AW'(CENTER_OFFSET - 1);
    localparam logic [AW-1:0] HI_START  = AW'(CENTER_OFFSET + 1);
    localparam logic [AW-1:0] MID_OFS   = AW'(CENTER_OFFSET);
    localparam logic [AW-1:0] PTR_STEP  = AW'(2);
    localparam logic [AW-1:0] PTR_ONE   = AW'(1);
    localparam logic [CW-1:0] ISS_MID   = CW'(HALF_TAPS);
    localparam logic [CW-1:0] ISS_LAST  = CW'(HALF_TAPS - 1);
    localparam logic [CW-1:0] ISS_ONE   = CW'(1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // Control state.
    logic [1:0]            r_state, n_state;
    logic [AW-1:0]         r_wp;
    logic [CW-1:0]         r_iss;
    logic [RING_DEPTH-1:0] r_vld;
    t_coef                 r_coef [NUM_COEFS];
    logic                  r_rd_v, r_rd_mid, r_rd_last;
    logic                  r_df_v, r_df_last;
    logic                  r_pr_v, r_pr_last;
    logic                  r_out_v;

    // Datapath registers.
    t_sample               r_mem [RING_DEPTH];
    logic [AW-1:0]         r_lo, r_hi, r_mid;
    t_sample               r_rd_a, r_rd_b;
    logic                  r_rd_a_ok, r_rd_b_ok;
    t_tap                  r_rd_tap, r_df_tap;
    t_diff                 r_diff;
    t_prod                 r_prod;
    t_acc                  r_acc;
    t_sample               r_inph;
    t_quad                 r_quad;
    t_sample               r_out_inph;

    logic                  accept, issue, issue_mid, fin_go;
    logic [AW-1:0]         addr_a;
    t_sample               rd_a, rd_b;
    t_acc                  shifted;
    t_quad                 quad_sat;

    assign accept    = (r_state == S_IDLE) && i_in.valid;
    assign issue     = (r_state == S_RUN) && (r_iss <= ISS_MID);
    assign issue_mid = (r_iss == ISS_MID);
    assign addr_a    = issue_mid ? r_mid : r_lo;
    assign fin_go    = (r_state == S_FIN) && (!r_out_v || o_out.ready);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_v;
    assign o_out.quad_out    = r_quad;
    assign o_out.inphase_out = r_out_inph;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_pr_v && r_pr_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers, coefficients and ring valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_iss     <= '0;
            r_vld     <= '0;
            r_rd_v    <= 1'b0;
            r_rd_mid  <= 1'b0;
            r_rd_last <= 1'b0;
            r_df_v    <= 1'b0;
            r_df_last <= 1'b0;
            r_pr_v    <= 1'b0;
            r_pr_last <= 1'b0;
            r_out_v   <= 1'b0;
            for (int i = 0; i < NUM_COEFS; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_coef[i_cfg_idx] <= i_cfg_data;
            end
            if (accept) begin
                r_vld[r_wp] <= 1'b1;
                r_wp        <= r_wp - PTR_ONE;
                r_iss       <= '0;
            end else if (issue) begin
                r_iss <= r_iss + ISS_ONE;
            end
            r_rd_v    <= issue && !issue_mid;
            r_rd_mid  <= issue && issue_mid;
            r_rd_last <= (r_iss == ISS_LAST);
            r_df_v    <= r_rd_v;
            r_df_last <= r_rd_last;
            r_pr_v    <= r_df_v;
            r_pr_last <= r_df_last;
            if (fin_go) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Ring memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_wp] <= i_in.sample_in;
        end
        r_rd_a    <= r_mem[addr_a];
        r_rd_b    <= r_mem[r_hi];
        r_rd_a_ok <= r_vld[addr_a];
        r_rd_b_ok <= r_vld[r_hi];
    end

    // Entries never written since reset read as zero.
    assign rd_a = r_rd_a_ok ? r_rd_a : '0;
    assign rd_b = r_rd_b_ok ? r_rd_b : '0;

    // Tap-pair addressing and the subtract, multiply, accumulate pipeline.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lo  <= r_wp + LO_START;
            r_hi  <= r_wp + HI_START;
            r_mid <= r_wp + MID_OFS;
        end else if (issue && !issue_mid) begin
            r_lo <= r_lo - PTR_STEP;
            r_hi <= r_hi + PTR_STEP;
        end
        r_rd_tap <= t_tap'(r_iss);
        r_df_tap <= r_rd_tap;
        r_diff   <= {rd_b[SAMPLE_W-1], rd_b} - {rd_a[SAMPLE_W-1], rd_a};
        if (r_rd_mid) begin
            r_inph <= rd_a;
        end
        r_prod <= r_diff * r_coef[r_df_tap];
        if (accept) begin
            r_acc <= '0;
        end else if (r_pr_v) begin
            r_acc <= r_acc + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // Floor shift and saturation to the output width.
    assign shifted = r_acc >>> FRAC_BITS;

    always_comb begin
        if (shifted[ACC_W-1:QUAD_W-1] == '0 || shifted[ACC_W-1:QUAD_W-1] == '1) begin
            quad_sat = shifted[QUAD_W-1:0];
        end else if (shifted[ACC_W-1]) begin
            quad_sat = {1'b1, {(QUAD_W - 1){1'b0}}};
        end else begin
            quad_sat = {1'b0, {(QUAD_W - 1){1'b1}}};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_quad     <= quad_sat;
            r_out_inph <= r_inph;
        end
    end

endmodule

FILE: src/hft_checker.sv
// Port-level checks on the Hilbert transformer core, bound to its top level.
// Depends on hft_pkg and hilbert_fir_transformer_core_macros.svh.
`include "hilbert_fir_transformer_core_macros.svh"

module hft_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input hft_pkg::t_quad   i_quad_out,
    input hft_pkg::t_sample i_inphase_out
);
    import hft_pkg::*;

    logic                         in_req, out_stall;
    logic [QUAD_W+SAMPLE_W-1:0]   out_pair;

    assign in_req    = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;
    assign out_pair  = {i_quad_out, i_inphase_out};

    // A stalled result stays offered and unchanged.
    `HFT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid)
    `HFT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(out_pair))

    // The core works on one request at a time.
    `HFT_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, in_req, !i_in_ready)

    // No result appears in the cycle straight after a request is taken.
    `HFT_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, in_req, !$rose(i_out_valid))

    // Requests are never taken on two consecutive edges.
    `HFT_ASSERT_NOW(a_ready_implies_free, i_clk, i_rst_n, in_req && $past(in_req), 1'b0)

endmodule

bind hilbert_fir_transformer_core hft_checker u_hft_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_quad_out    (o_out.quad_out),
    .i_inphase_out (o_out.inphase_out)
);
